// ===== hdl/lzwc_pkg.sv =====
// lzwc_pkg: types, constants and token classification shared by the
// lz window copy decoder modules. No dependencies.
`default_nettype none

package lzwc_pkg;

	localparam int WIN_AW    = 13;
	localparam int WIN_SIZE  = 1 << WIN_AW;
	localparam int SYM_W     = 9;
	localparam int BYTE_W    = 8;
	localparam int MAX_MATCH = 64;
	localparam int LEN_W     = $clog2(MAX_MATCH + 1);
	localparam int LEN_BIAS  = 254;
	localparam int LIT_LIMIT = 256;
	localparam int Q_DEPTH   = 2;
	localparam int Q_AW      = $clog2(Q_DEPTH);
	localparam int Q_CW      = $clog2(Q_DEPTH + 1);

	typedef enum logic [1:0] {
		TOK_LIT   = 2'd0,
		TOK_MATCH = 2'd1,
		TOK_BAD   = 2'd2
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t          kind;
		logic [BYTE_W-1:0]  lit;
		logic [LEN_W-1:0]   len;
		logic [WIN_AW-1:0]  back_dist;
	} tok_t;

	function automatic tok_t classify(input logic [SYM_W-1:0] symbol,
			input logic [WIN_AW-1:0] distance);
		tok_t             t;
		logic [SYM_W-1:0] len_full;
		len_full    = symbol - SYM_W'(LEN_BIAS);
		t.lit       = symbol[BYTE_W-1:0];
		t.len       = len_full[LEN_W-1:0];
		t.back_dist = distance;
		if (symbol < SYM_W'(LIT_LIMIT)) begin
			t.kind = TOK_LIT;
		end else if (len_full > SYM_W'(MAX_MATCH)) begin
			t.kind = TOK_BAD;
		end else begin
			t.kind = TOK_MATCH;
		end
		return t;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/lz_window_copy_decoder_core.sv =====
// LZ77 back end with an 8 KiB ring window: takes one decoded token per
// input transaction and gives one output transaction per byte. A match
// first sets up the source, then does the first window read, then gives
// one byte a cycle from the single-port read of the window while the
// output is not stalled, and an over-long match gives one flagged
// transaction. A short token queue lets the input side keep taking tokens
// while the copier works. The window reads as zero after reset without a
// clearing pass, so the block accepts work straight away.
// Depends on lzwc_pkg, lzwc_front, lzwc_fifo and lzwc_back.
`default_nettype none

module lz_window_copy_decoder_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [lzwc_pkg::SYM_W-1:0]   symbol,
	input  wire logic [lzwc_pkg::WIN_AW-1:0]  distance,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [lzwc_pkg::BYTE_W-1:0]       out_byte,
	output logic                              last,
	output logic                              bad_symbol
);
	import lzwc_pkg::*;

	logic f_valid;
	logic f_ready;
	tok_t f_tok;
	logic q_valid;
	logic q_ready;
	tok_t q_tok;

	lzwc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.symbol    (symbol),
		.distance  (distance),
		.tok_valid (f_valid),
		.tok       (f_tok),
		.tok_ready (f_ready)
	);

	lzwc_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_tok   (f_tok),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_tok    (q_tok)
	);

	lzwc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.tok_valid  (q_valid),
		.tok_ready  (q_ready),
		.tok        (q_tok),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.last       (last),
		.bad_symbol (bad_symbol)
	);

endmodule

`default_nettype wire

// ===== hdl/lzwc_front.sv =====
// lzwc_front: input stage, takes token transactions, classifies them and
// holds one classified token for the queue. Depends on lzwc_pkg.
`default_nettype none

module lzwc_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [lzwc_pkg::SYM_W-1:0]   symbol,
	input  wire logic [lzwc_pkg::WIN_AW-1:0]  distance,
	output logic                              tok_valid,
	output lzwc_pkg::tok_t                    tok,
	input  wire logic                         tok_ready
);
	import lzwc_pkg::*;

	logic v_s1;
	tok_t tok_s1;

	assign in_ready  = !v_s1 || tok_ready;
	assign tok_valid = v_s1;
	assign tok       = tok_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			tok_s1 <= classify(symbol, distance);
		end
	end

endmodule

`default_nettype wire

// ===== hdl/lzwc_fifo.sv =====
// lzwc_fifo: short token queue between the front stage and the copier.
// Depends on lzwc_pkg.
`default_nettype none

module lzwc_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push_valid,
	output logic                push_ready,
	input  wire lzwc_pkg::tok_t push_tok,
	output logic                pop_valid,
	input  wire logic           pop_ready,
	output lzwc_pkg::tok_t      pop_tok
);
	import lzwc_pkg::*;

	tok_t            slot_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_CW-1:0] cnt_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = cnt_q != Q_CW'(Q_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_tok    = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + Q_CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - Q_CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_tok;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/lzwc_back.sv =====
// lzwc_back: copier with the ring window memory and the output register.
// Carries out literal, match and bad-symbol tokens. Depends on lzwc_pkg.
`default_nettype none

module lzwc_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         tok_valid,
	output logic                              tok_ready,
	input  wire lzwc_pkg::tok_t               tok,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [lzwc_pkg::BYTE_W-1:0]       out_byte,
	output logic                              last,
	output logic                              bad_symbol
);
	import lzwc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RD   = 3'b010,
		ST_DT   = 3'b100
	} state_t;

	state_t             state_q, state_d;
	logic [WIN_AW-1:0]  wp_q;
	logic               wrapped_q;
	logic [WIN_AW-1:0]  src_q, src_d;
	logic [LEN_W-1:0]   remain_q, remain_d;

	logic [BYTE_W-1:0]  mem [WIN_SIZE];
	logic [BYTE_W-1:0]  rdata_q;
	logic               byp_q;
	logic [BYTE_W-1:0]  byp_data_q;
	logic               unwr_q;

	logic               out_valid_q;
	logic [BYTE_W-1:0]  out_byte_q;
	logic               last_q;
	logic               bad_q;

	logic               slot_free;
	logic               we;
	logic [BYTE_W-1:0]  wdata;
	logic [WIN_AW-1:0]  raddr;
	logic [BYTE_W-1:0]  cp_byte;
	logic               emit;
	logic [BYTE_W-1:0]  e_byte;
	logic               e_last;
	logic               e_bad;

	assign slot_free  = !out_valid_q || out_ready;
	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign last       = last_q;
	assign bad_symbol = bad_q;

	// same-cycle write wins, then never-written positions read as zero
	assign cp_byte = byp_q ? byp_data_q : (unwr_q ? '0 : rdata_q);

	always_comb begin
		state_d   = state_q;
		src_d     = src_q;
		remain_d  = remain_q;
		tok_ready = 1'b0;
		we        = 1'b0;
		wdata     = tok.lit;
		raddr     = src_q;
		emit      = 1'b0;
		e_byte    = '0;
		e_last    = 1'b1;
		e_bad     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (tok_valid) begin
					unique case (tok.kind)
						TOK_LIT: begin
							if (slot_free) begin
								tok_ready = 1'b1;
								we        = 1'b1;
								emit      = 1'b1;
								e_byte    = tok.lit;
							end
						end
						TOK_MATCH: begin
							tok_ready = 1'b1;
							src_d     = wp_q - tok.back_dist - WIN_AW'(1);
							remain_d  = tok.len;
							state_d   = ST_RD;
						end
						TOK_BAD: begin
							if (slot_free) begin
								tok_ready = 1'b1;
								emit      = 1'b1;
								e_bad     = 1'b1;
							end
						end
						default: begin
							tok_ready = 1'b1;
						end
					endcase
				end
			end
			ST_RD: begin
				state_d = ST_DT;
			end
			ST_DT: begin
				if (slot_free) begin
					we       = 1'b1;
					wdata    = cp_byte;
					emit     = 1'b1;
					e_byte   = cp_byte;
					e_last   = remain_q == LEN_W'(1);
					src_d    = src_q + WIN_AW'(1);
					remain_d = remain_q - LEN_W'(1);
					raddr    = src_q + WIN_AW'(1);
					if (remain_q == LEN_W'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= '0;
			wrapped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (we) begin
				wp_q <= wp_q + WIN_AW'(1);
				if (wp_q == '1) begin
					wrapped_q <= 1'b1;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		src_q    <= src_d;
		remain_q <= remain_d;
		if (emit) begin
			out_byte_q <= e_byte;
			last_q     <= e_last;
			bad_q      <= e_bad;
		end
	end

	// window memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wp_q] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// positions at or past the write pointer are untouched until the first wrap
	always_ff @(posedge clk) begin
		byp_q      <= we && (raddr == wp_q);
		byp_data_q <= wdata;
		unwr_q     <= !wrapped_q && (raddr >= wp_q);
	end

endmodule

`default_nettype wire
